### hdl/grouped_median_selector_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the grouped median selector
// Clocked on aclk, held off while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef GROUPED_MEDIAN_SELECTOR_DEFINES_SVH
`define GROUPED_MEDIAN_SELECTOR_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define GMS_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Expression must never be true outside reset.
`define GMS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

### hdl/gms_pkg.sv
// ---------------------------------------------------------------------------
// gms_pkg
// Shared widths and parameter defaults for the grouped median selector.
// ---------------------------------------------------------------------------
`default_nettype none

package gms_pkg;

    // fixed field widths
    localparam int AGE_W = 7;
    localparam int MED_W = 7;

    // defaults for the top-level parameters
    localparam int MAX_AGE_DEF     = 127;
    localparam int MAX_RECORDS_DEF = 1024;

endpackage

`default_nettype wire

### hdl/grouped_median_selector.sv
// ---------------------------------------------------------------------------
// grouped_median_selector
// Per-group age histograms with a median walk at the end of each set.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready, s_age, s_group, s_last) takes one record
//   per transfer; ages above MAX_AGE saturate to it. Once MAX_RECORDS
//   records of a set are counted, further records are dropped, but a
//   dropped record marked last still closes the set.
//   Output channel (m_valid/m_ready) gives one transfer per set: the median
//   (element at sorted index n/2) of all records, of group 0 and of
//   group 1, each 0 for an empty group.
//   Throughput: one record per cycle while loading. Each record is a
//   read-modify-write of a histogram RAM; a one-entry forwarding register
//   covers two consecutive records hitting the same bin.
//   Walk: after the last record, the block passes a settle state, walks
//   both histogram RAMs once, one age bin per cycle, and zeroes each bin
//   as it passes, then a tail state before the result is handed over;
//   s_ready stays low over that time.
//   Reset: a clearing pass over every bin zeroes both RAMs; s_ready
//   stays low until it ends.
//   Stall: the result sits in an output register, so loading of the next
//   set goes on while m_ready is low; only the end of the next walk waits
//   for the output register to empty.
// ---------------------------------------------------------------------------
`default_nettype none

module grouped_median_selector #(
    parameter int MAX_AGE     = gms_pkg::MAX_AGE_DEF,
    parameter int MAX_RECORDS = gms_pkg::MAX_RECORDS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [gms_pkg::AGE_W-1:0]  s_age,
    input  wire logic                       s_group,
    input  wire logic                       s_last,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [gms_pkg::MED_W-1:0]  m_median_all,
    output logic      [gms_pkg::MED_W-1:0]  m_median_group0,
    output logic      [gms_pkg::MED_W-1:0]  m_median_group1
);

    import gms_pkg::*;

    `include "grouped_median_selector_defines.svh"

    localparam int BINS = MAX_AGE + 1;
    localparam int AW   = $clog2(BINS);
    localparam int CW   = $clog2(MAX_RECORDS + 1);

    localparam logic [AW-1:0] LAST_BIN  = AW'(MAX_AGE);
    localparam logic [CW-1:0] REC_LIMIT = CW'(MAX_RECORDS);

    // state codes
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_SETTLE = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_TAIL   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] walk_addr_reg;

    // load pipeline: record whose RAM read is in flight
    logic          s1_valid_reg;
    logic [AW-1:0] s1_bin_reg;
    logic          s1_grp_reg;

    // forwarding of the last histogram write
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_bin_reg;
    logic          fwd_grp_reg;
    logic [CW-1:0] fwd_val_reg;

    // walk pipeline: bin whose RAM read is in flight
    logic          p_valid_reg;
    logic [AW-1:0] p_addr_reg;

    logic [CW-1:0] count0_reg, count1_reg;
    logic [CW-1:0] seen0_reg, seen1_reg, seen_all_reg;
    logic          found0_reg, found1_reg, found_all_reg;
    logic [AW-1:0] med0_reg, med1_reg, med_all_reg;

    logic          m_valid_reg;
    logic [MED_W-1:0] m_all_reg, m_g0_reg, m_g1_reg;

    logic          in_xfer, out_xfer, out_free, kept;
    logic [AW-1:0] in_bin;
    logic [CW-1:0] total;
    logic [CW-1:0] rd0, rd1, base, inc;
    logic [CW-1:0] sum0, sum1, sum_all;
    logic          we0, we1;
    logic [AW-1:0] waddr, raddr;
    logic [CW-1:0] wdata;

    assign s_ready  = (state_reg == ST_LOAD);
    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid_reg && m_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign total    = CW'(count0_reg + count1_reg);
    assign kept     = (total < REC_LIMIT);

    // saturate the age to the top bin
    always_comb begin
        if (int'(s_age) > MAX_AGE) begin
            in_bin = LAST_BIN;
        end else begin
            in_bin = AW'(s_age);
        end
    end

    // histogram RAMs, one per group
    gms_ram #(.WIDTH(CW), .DEPTH(BINS)) u_hist0 (
        .clk(aclk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd0)
    );

    gms_ram #(.WIDTH(CW), .DEPTH(BINS)) u_hist1 (
        .clk(aclk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1)
    );

    // increment: take the forwarded value if the previous write hit this bin
    always_comb begin
        if (fwd_valid_reg && fwd_bin_reg == s1_bin_reg && fwd_grp_reg == s1_grp_reg) begin
            base = fwd_val_reg;
        end else if (s1_grp_reg) begin
            base = rd1;
        end else begin
            base = rd0;
        end
        inc = CW'(base + 1'b1);
    end

    // write port: clearing pass, walk zeroing, or record increment
    always_comb begin
        raddr = (state_reg == ST_LOAD) ? in_bin : walk_addr_reg;
        we0   = 1'b0;
        we1   = 1'b0;
        waddr = walk_addr_reg;
        wdata = '0;
        if (state_reg == ST_CLEAR) begin
            we0 = 1'b1;
            we1 = 1'b1;
        end else if (p_valid_reg) begin
            we0   = 1'b1;
            we1   = 1'b1;
            waddr = p_addr_reg;
        end else if (s1_valid_reg) begin
            we0   = !s1_grp_reg;
            we1   = s1_grp_reg;
            waddr = s1_bin_reg;
            wdata = inc;
        end
    end

    // running sums of the walk
    assign sum0    = CW'(seen0_reg + rd0);
    assign sum1    = CW'(seen1_reg + rd1);
    assign sum_all = CW'(seen_all_reg + rd0 + rd1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (walk_addr_reg == LAST_BIN) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (in_xfer && s_last) begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: state_next = ST_WALK;
            ST_WALK: begin
                if (walk_addr_reg == LAST_BIN) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            walk_addr_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            p_valid_reg   <= 1'b0;
            count0_reg    <= '0;
            count1_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            s1_valid_reg  <= in_xfer && kept;
            fwd_valid_reg <= s1_valid_reg;
            p_valid_reg   <= (state_reg == ST_WALK);

            // advance the bin pointer during the clearing pass and the walk
            if (state_reg == ST_CLEAR || state_reg == ST_WALK) begin
                walk_addr_reg <= (walk_addr_reg == LAST_BIN) ? '0 : AW'(walk_addr_reg + 1'b1);
            end else if (state_reg == ST_SETTLE) begin
                walk_addr_reg <= '0;
            end

            if (in_xfer && kept) begin
                if (s_group) begin
                    count1_reg <= CW'(count1_reg + 1'b1);
                end else begin
                    count0_reg <= CW'(count0_reg + 1'b1);
                end
            end

            // hand over the result and drop the counts of the finished set
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                count0_reg  <= '0;
                count1_reg  <= '0;
            end else if (out_xfer) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        s1_bin_reg  <= in_bin;
        s1_grp_reg  <= s_group;
        fwd_bin_reg <= s1_bin_reg;
        fwd_grp_reg <= s1_grp_reg;
        fwd_val_reg <= inc;
        p_addr_reg  <= walk_addr_reg;

        if (state_reg == ST_SETTLE) begin
            seen0_reg     <= '0;
            seen1_reg     <= '0;
            seen_all_reg  <= '0;
            found0_reg    <= 1'b0;
            found1_reg    <= 1'b0;
            found_all_reg <= 1'b0;
            med0_reg      <= '0;
            med1_reg      <= '0;
            med_all_reg   <= '0;
        end else if (p_valid_reg) begin
            seen0_reg    <= sum0;
            seen1_reg    <= sum1;
            seen_all_reg <= sum_all;
            // the first bin whose running count passes n/2 holds the median
            if (!found0_reg && sum0 > (count0_reg >> 1)) begin
                found0_reg <= 1'b1;
                med0_reg   <= p_addr_reg;
            end
            if (!found1_reg && sum1 > (count1_reg >> 1)) begin
                found1_reg <= 1'b1;
                med1_reg   <= p_addr_reg;
            end
            if (!found_all_reg && sum_all > (total >> 1)) begin
                found_all_reg <= 1'b1;
                med_all_reg   <= p_addr_reg;
            end
        end

        if (state_reg == ST_DONE && out_free) begin
            m_all_reg <= MED_W'(med_all_reg);
            m_g0_reg  <= MED_W'(med0_reg);
            m_g1_reg  <= MED_W'(med1_reg);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_median_all    = m_all_reg;
    assign m_median_group0 = m_g0_reg;
    assign m_median_group1 = m_g1_reg;

    // checks
    `GMS_ASSERT_NEVER(a_wport_clash, s1_valid_reg && p_valid_reg, "load write and walk write collide")
    `GMS_ASSERT_NEVER(a_count_limit, (32'(count0_reg) + 32'(count1_reg)) > MAX_RECORDS, "record count exceeds limit")
    `GMS_ASSERT_CLK(a_last_settles, (in_xfer && s_last) |=> (state_reg == ST_SETTLE), "last record did not start the walk")
    `GMS_ASSERT_CLK(a_done_output, (state_reg == ST_DONE && out_free) |=> (m_valid_reg && count0_reg == '0 && count1_reg == '0), "result not handed over")
    `GMS_ASSERT_NEVER(a_no_write_in_load_walk, s1_valid_reg && state_reg == ST_WALK, "increment pending during walk")

endmodule

`default_nettype wire

### hdl/gms_ram.sv
// ---------------------------------------------------------------------------
// gms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module gms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### test/grouped_median_selector_tb.sv
// ---------------------------------------------------------------------------
// grouped_median_selector_tb
// Drives sets of age/group records into the median selector and checks
// each set's three medians against a histogram predictor kept in the bench.
// ---------------------------------------------------------------------------
`default_nettype none

module grouped_median_selector_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import gms_pkg::*;

    localparam int AGE_BINS      = MAX_AGE_DEF + 1;
    localparam int IDLE_PCT      = 36;
    // Window of cycles in which neither side idles.
    localparam int QUIET_FROM    = 1500;
    localparam int QUIET_TO      = 4000;
    // Longest legal gap is the clearing pass or one walk plus a short stall.
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = MAX_AGE_DEF + 40;
    localparam int RANDOM_ITEMS  = 620;

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic             grp;
        logic             last;
        logic             drain;   // hold off until every result has come
    } record_t;

    typedef struct packed {
        logic [MED_W-1:0] all;
        logic [MED_W-1:0] g0;
        logic [MED_W-1:0] g1;
    } medians_t;

    logic             aclk    = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [AGE_W-1:0] s_age   = '0;
    logic             s_group = 1'b0;
    logic             s_last  = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [MED_W-1:0] m_median_all;
    logic [MED_W-1:0] m_median_group0;
    logic [MED_W-1:0] m_median_group1;

    record_t  record_queue[$];
    medians_t medians_due[$];
    record_t  next_record;

    // Predictor state: per-group age histograms and record counts.
    int unsigned age_hist0 [AGE_BINS];
    int unsigned age_hist1 [AGE_BINS];
    int unsigned tally0 = 0;
    int unsigned tally1 = 0;

    int  cyc          = 0;
    int  stall_cycles = 0;
    int  fail_count   = 0;
    int  sets_closed  = 0;
    int  records_seen = 0;
    int  records_cut  = 0;
    int  results_seen = 0;
    logic s_taken     = 1'b0;
    bit   quiet;

    assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

    grouped_median_selector u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_age           (s_age),
        .s_group         (s_group),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_median_all    (m_median_all),
        .m_median_group0 (m_median_group0),
        .m_median_group1 (m_median_group1)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // Walk the chosen histograms upward and return the age at sorted index n/2.
    function automatic logic [MED_W-1:0] walk_median(bit use0, bit use1, int unsigned n);
        int unsigned seen = 0;
        if (n == 0) return '0;
        for (int a = 0; a < AGE_BINS; a++) begin
            if (use0) seen += age_hist0[a];
            if (use1) seen += age_hist1[a];
            if (seen > n / 2) return a[MED_W-1:0];
        end
        return MAX_AGE_DEF[MED_W-1:0];
    endfunction

    // Add one accepted record unless the set is full; on the last record,
    // queue the set's medians and empty the histograms for the next set.
    task automatic tally_record(record_t r);
        int       bin;
        medians_t m;
        bin = (r.age > MAX_AGE_DEF) ? MAX_AGE_DEF : int'(r.age);
        records_seen++;
        if (tally0 + tally1 < MAX_RECORDS_DEF) begin
            if (r.grp == 1'b0) begin
                age_hist0[bin]++;
                tally0++;
            end else begin
                age_hist1[bin]++;
                tally1++;
            end
        end else begin
            records_cut++;   // set is full: drop the record, keep its last flag
        end
        if (r.last) begin
            m.all = walk_median(1'b1, 1'b1, tally0 + tally1);
            m.g0  = walk_median(1'b1, 1'b0, tally0);
            m.g1  = walk_median(1'b0, 1'b1, tally1);
            medians_due.insert(medians_due.size(), m);
            for (int a = 0; a < AGE_BINS; a++) begin
                age_hist0[a] = 0;
                age_hist1[a] = 0;
            end
            tally0 = 0;
            tally1 = 0;
            sets_closed++;
        end
    endtask

    // -----------------------------------------------------------------------
    // Stimulus construction
    // -----------------------------------------------------------------------

    task automatic add_record(int age, bit grp, bit last, bit drain = 1'b0);
        record_t r;
        r.age   = age[AGE_W-1:0];
        r.grp   = grp;
        r.last  = last;
        r.drain = drain;
        record_queue.insert(record_queue.size(), r);
    endtask

    // Pick an age in the flavour of the current set.
    function automatic int pick_age(int flavour, int centre);
        case (flavour)
            0: pick_age = $urandom_range(MAX_AGE_DEF, 0);
            1: pick_age = centre + $urandom_range(6, 0);
            2: pick_age = ($urandom_range(1, 0) == 1) ? MAX_AGE_DEF : 0;
            default: pick_age = $urandom_range(MAX_AGE_DEF, 0);
        endcase
        if (pick_age > MAX_AGE_DEF) pick_age = MAX_AGE_DEF;
    endfunction

    // -----------------------------------------------------------------------
    // Driver: present records from the queue, change inputs on falling edges
    // -----------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99, 0) >= IDLE_PCT);
            // Hold the payload until the transfer has happened.
            if (!s_valid || s_taken) begin
                if (record_queue.size() > 0 &&
                    !(record_queue[0].drain && medians_due.size() > 0) &&
                    (quiet || $urandom_range(99, 0) >= IDLE_PCT)) begin
                    next_record = record_queue[0];
                    record_queue.delete(0);
                    s_age   <= next_record.age;
                    s_group <= next_record.grp;
                    s_last  <= next_record.last;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: sample transfers on rising edges, predict and compare
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        medians_t want;
        record_t  got;
        cyc     <= cyc + 1;
        s_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (medians_due.size() == 0) begin
                    $error("result transfer with no closed set waiting");
                    fail_count++;
                end else begin
                    want = medians_due[0];
                    medians_due.delete(0);
                    if (m_median_all !== want.all) begin
                        $error("median_all: expected %0d, got %0d", want.all, m_median_all);
                        fail_count++;
                    end
                    if (m_median_group0 !== want.g0) begin
                        $error("median_group0: expected %0d, got %0d",
                               want.g0, m_median_group0);
                        fail_count++;
                    end
                    if (m_median_group1 !== want.g1) begin
                        $error("median_group1: expected %0d, got %0d",
                               want.g1, m_median_group1);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                got.age   = s_age;
                got.grp   = s_group;
                got.last  = s_last;
                got.drain = 1'b0;
                tally_record(got);
            end
            // Watchdog: count cycles with no transfer on either channel.
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial begin
        int queued;
        int len;
        int flavour;
        int centre;
        int grp_mode;
        bit grp;

        for (int a = 0; a < AGE_BINS; a++) begin
            age_hist0[a] = 0;
            age_hist1[a] = 0;
        end

        // Directed sets.
        // Single record at the lowest age, group 1 empty.
        add_record(0, 1'b0, 1'b1);
        // Single record at the highest age, group 0 empty.
        add_record(MAX_AGE_DEF, 1'b1, 1'b1);
        // Two records: even count takes the upper median.
        add_record(10, 1'b0, 1'b0);
        add_record(20, 1'b1, 1'b1);
        // Extremes mixed across both groups, even counts per group.
        add_record(5, 1'b0, 1'b0);
        add_record(MAX_AGE_DEF, 1'b1, 1'b0);
        add_record(0, 1'b1, 1'b0);
        add_record(5, 1'b0, 1'b1);
        // Consecutive records on the same bin.
        add_record(42, 1'b1, 1'b0);
        add_record(42, 1'b1, 1'b0);
        add_record(42, 1'b1, 1'b0);
        add_record(43, 1'b0, 1'b1);
        // Group 0 only, odd count, with the sender paused for the results first.
        add_record(100, 1'b0, 1'b0, 1'b1);
        add_record(3, 1'b0, 1'b0);
        add_record(64, 1'b0, 1'b0);
        add_record(1, 1'b0, 1'b0);
        add_record(126, 1'b0, 1'b1);
        // Straight after a set: new set on same bins as the last one.
        add_record(126, 1'b1, 1'b0);
        add_record(126, 1'b0, 1'b1);

        // Random sets, mostly short.
        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            case ($urandom_range(99, 0)) inside
                [0:69]:  len = $urandom_range(12, 1);
                [70:91]: len = $urandom_range(40, 13);
                default: len = $urandom_range(120, 41);
            endcase
            flavour  = $urandom_range(3, 0);
            centre   = $urandom_range(MAX_AGE_DEF, 0);
            grp_mode = $urandom_range(3, 0);
            for (int i = 0; i < len; i++) begin
                case (grp_mode)
                    0:       grp = 1'b0;
                    1:       grp = 1'b1;
                    default: grp = $urandom_range(1, 0);
                endcase
                add_record(pick_age(flavour, centre), grp, i == len - 1,
                           i == 0 && $urandom_range(14, 0) == 0);
            end
            queued += len;
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every record to be taken, then for every result.
        while (record_queue.size() > 0 || s_valid) @(posedge aclk);
        while (medians_due.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (medians_due.size() != 0) begin
            $error("%0d sets closed without a result", medians_due.size());
            fail_count++;
        end
        $display("Ran %0d records in %0d sets, %0d dropped at the record cap;",
                 records_seen, sets_closed, records_cut);
        $display("checked %0d median results, %0d mismatches.", results_seen, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
